// ===== rtl/core/srb_pkg.sv =====
// shared types, constants and helpers of the sequence reorder buffer
`default_nettype none

package srb_pkg;

    localparam int RING_DEPTH  = 16;
    localparam int TAG_BITS    = 16;
    localparam int IDX_W       = $clog2(RING_DEPTH);
    localparam int CNT_W       = $clog2(RING_DEPTH + 1);
    localparam int IN_Q_DEPTH  = 2;
    localparam int RES_Q_DEPTH = 4;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    localparam logic CMD_ARRIVE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam logic EV_VERDICT = 1'b0;
    localparam logic EV_FORWARD = 1'b1;

    localparam logic [1:0] VD_ACCEPT = 2'd0;
    localparam logic [1:0] VD_QUEUED = 2'd1;
    localparam logic [1:0] VD_DROP   = 2'd2;

    localparam logic REG_TIMEOUT = 1'b0;

    typedef struct packed {
        logic        command;
        logic [31:0] seq_num;
        logic [15:0] tag;
        logic [15:0] hold_ticks;
    } item_t;

    typedef struct packed {
        logic        event_kind;
        logic [1:0]  verdict;
        logic [15:0] out_tag;
        logic [31:0] out_seq;
        logic        last;
    } result_t;

    // front queue to engine
    typedef struct packed {
        logic  valid;
        item_t item;
    } front_q_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ARRIVE,
        ST_SLIDE,
        ST_PLACE,
        ST_RUN,
        ST_VERDICT,
        ST_TICK,
        ST_DONE
    } eng_state_t;

    typedef enum logic [1:0] {
        CL_INORDER,
        CL_EARLY,
        CL_LATE
    } arr_class_t;

    // a is after b, modulo 2^32
    function automatic logic is_after(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = b - a;
        return d[31];
    endfunction

    // ring index plus offset, offset at most the ring depth
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
        if (s >= (CNT_W+1)'(RING_DEPTH))
        begin
            s = s - (CNT_W+1)'(RING_DEPTH);
        end
        return IDX_W'(s);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/srb_front.sv =====
// input queue that takes items and presents them to the engine
`default_nettype none

module srb_front (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               push,
    output logic              full,
    input  srb_pkg::item_t    item,
    output srb_pkg::front_q_t q_out,
    input  wire               q_pop
);
    import srb_pkg::*;

    localparam int PTR_W = (IN_Q_DEPTH > 1) ? $clog2(IN_Q_DEPTH) : 1;
    localparam int QC_W  = $clog2(IN_Q_DEPTH + 1);

    item_t             mem_reg [IN_Q_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == QC_W'(IN_Q_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = q_pop && (count_reg != '0);

    assign q_out.valid = (count_reg != '0);
    assign q_out.item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(IN_Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(IN_Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/srb_res_q.sv =====
// result queue between the engine and the result ports
`default_nettype none

module srb_res_q (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              wr_en,
    input  srb_pkg::result_t wr_data,
    output logic             wr_full,
    output logic             empty,
    input  wire              pop,
    output srb_pkg::result_t result
);
    import srb_pkg::*;

    localparam int PTR_W = $clog2(RES_Q_DEPTH);
    localparam int QC_W  = $clog2(RES_Q_DEPTH + 1);

    result_t           mem_reg [RES_Q_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign wr_full = (count_reg == QC_W'(RES_Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = wr_en && !wr_full;
    assign do_pop  = pop && !empty;
    assign result  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(RES_Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(RES_Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/srb_engine.sv =====
// back end: ring state and the sequencer that slides, stores and releases
`default_nettype none

module srb_engine (
    input  wire               clk,
    input  wire               rst_n,
    input  srb_pkg::front_q_t q_in,
    output logic              q_pop,
    input  wire [15:0]        resync_timeout,
    output logic              res_push,
    output srb_pkg::result_t  res_data,
    input  wire               res_full
);
    import srb_pkg::*;

    eng_state_t        state_reg, state_next;
    logic              full_reg [RING_DEPTH];
    logic              full_next [RING_DEPTH];
    logic              sent_reg [RING_DEPTH];
    logic              sent_next [RING_DEPTH];
    logic [TAG_BITS-1:0] tag_mem_reg [RING_DEPTH];
    logic [TAG_BITS-1:0] tag_mem_next [RING_DEPTH];
    logic [31:0]       dl_mem_reg [RING_DEPTH];
    logic [31:0]       dl_mem_next [RING_DEPTH];
    logic [IDX_W-1:0]  oldest_slot_reg, oldest_slot_next;
    logic [31:0]       oldest_seq_reg, oldest_seq_next;
    logic [31:0]       newest_seq_reg, newest_seq_next;
    logic [31:0]       exp_reg, exp_next;
    logic [31:0]       rdl_reg, rdl_next;
    logic [31:0]       time_reg, time_next;

    logic [31:0]       seq_reg, seq_next;
    logic [15:0]       tag_reg, tag_next;
    logic [15:0]       hold_ticks_reg, hold_ticks_next;
    arr_class_t        class_reg, class_next;
    logic [1:0]        verdict_reg, verdict_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  steps_reg, steps_next;
    logic              prev_reg, prev_next;
    result_t           hold_reg, hold_next;
    logic              hold_vld_reg, hold_vld_next;

    // decode
    logic              cur_pend;
    logic [IDX_W-1:0]  idx_inc;
    logic              resync;
    logic [31:0]       arr_exp;
    logic              arr_inorder, arr_early, needs_slide;
    logic [31:0]       steps_raw;
    logic [CNT_W-1:0]  steps_clip;
    logic [31:0]       place_d;
    logic              place_hit;
    logic [IDX_W-1:0]  place_slot;
    logic [31:0]       tick_d;
    logic              tick_hit;
    logic              run_go;
    logic              tick_rel;
    logic              emit_req, emit_ok, stall;
    result_t           new_res;
    logic [31:0]       new_oldest;

    always_comb
    begin
        cur_pend   = full_reg[idx_reg] && !sent_reg[idx_reg];
        idx_inc    = wrap_add(idx_reg, CNT_W'(1));
        resync     = ((time_reg - rdl_reg) & 32'h8000_0000) == 32'd0;
        arr_exp    = resync ? seq_reg : exp_reg;
        arr_inorder = (seq_reg == arr_exp);
        arr_early   = is_after(seq_reg, arr_exp);
        needs_slide = (arr_inorder || arr_early)
                      && !(is_after(seq_reg, oldest_seq_reg - 32'd1)
                           && is_after(newest_seq_reg + 32'd1, seq_reg));
        steps_raw  = seq_reg - newest_seq_reg;
        steps_clip = (steps_raw > 32'(RING_DEPTH)) ? CNT_W'(RING_DEPTH) : CNT_W'(steps_raw);
        place_d    = seq_reg - oldest_seq_reg;
        place_hit  = place_d < 32'(RING_DEPTH);
        place_slot = wrap_add(oldest_slot_reg, CNT_W'(place_d));
        tick_d     = exp_reg - oldest_seq_reg;
        tick_hit   = tick_d < 32'(RING_DEPTH);
        run_go     = (cnt_reg < CNT_W'(RING_DEPTH)) && cur_pend;
        tick_rel   = prev_reg || is_after(time_reg, dl_mem_reg[idx_reg]);
        new_oldest = seq_reg - 32'(RING_DEPTH) + 32'd1;

        unique case (state_reg)
            ST_SLIDE:   emit_req = (cnt_reg != steps_reg) && cur_pend;
            ST_RUN:     emit_req = run_go;
            ST_VERDICT: emit_req = 1'b1;
            ST_TICK:    emit_req = (cnt_reg != CNT_W'(RING_DEPTH)) && cur_pend && tick_rel;
            default:    emit_req = 1'b0;
        endcase
        emit_ok = !hold_vld_reg || !res_full;
        stall   = emit_req && !emit_ok;

        new_res.event_kind = EV_FORWARD;
        new_res.verdict    = VD_ACCEPT;
        new_res.out_tag    = 16'(tag_mem_reg[idx_reg]);
        new_res.last       = 1'b0;
        unique case (state_reg)
            ST_SLIDE: new_res.out_seq = oldest_seq_reg + 32'(cnt_reg);
            ST_RUN:   new_res.out_seq = seq_reg + 32'(cnt_reg);
            ST_VERDICT:
            begin
                new_res.event_kind = EV_VERDICT;
                new_res.verdict    = verdict_reg;
                new_res.out_tag    = tag_reg;
                new_res.out_seq    = seq_reg;
            end
            default:  new_res.out_seq = seq_reg;
        endcase
    end

    // the held result goes out once the next one, or the end of the item, is known
    assign res_push = hold_vld_reg
                      && ((emit_req && emit_ok) || (state_reg == ST_DONE && !res_full));
    always_comb
    begin
        res_data      = hold_reg;
        res_data.last = (state_reg == ST_DONE);
    end

    assign q_pop = (state_reg == ST_IDLE) && q_in.valid;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_in.valid)
                begin
                    if (q_in.item.command == CMD_TICK)
                    begin
                        state_next = tick_hit ? ST_TICK : ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_ARRIVE;
                    end
                end
            end
            ST_ARRIVE:  state_next = needs_slide ? ST_SLIDE : ST_PLACE;
            ST_SLIDE:
            begin
                if (cnt_reg == steps_reg)
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                if (place_hit && !full_reg[place_slot] && class_reg == CL_INORDER)
                begin
                    state_next = ST_RUN;
                end
                else
                begin
                    state_next = ST_VERDICT;
                end
            end
            ST_RUN:
            begin
                if (!run_go)
                begin
                    state_next = ST_VERDICT;
                end
            end
            ST_VERDICT:
            begin
                if (emit_ok)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_TICK:
            begin
                if (cnt_reg == CNT_W'(RING_DEPTH) || (cur_pend && !tick_rel))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!hold_vld_reg || !res_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        full_next        = full_reg;
        sent_next        = sent_reg;
        tag_mem_next     = tag_mem_reg;
        dl_mem_next      = dl_mem_reg;
        oldest_slot_next = oldest_slot_reg;
        oldest_seq_next  = oldest_seq_reg;
        newest_seq_next  = newest_seq_reg;
        exp_next         = exp_reg;
        rdl_next         = rdl_reg;
        time_next        = time_reg;
        seq_next         = seq_reg;
        tag_next         = tag_reg;
        hold_ticks_next  = hold_ticks_reg;
        class_next       = class_reg;
        verdict_next     = verdict_reg;
        idx_next         = idx_reg;
        cnt_next         = cnt_reg;
        steps_next       = steps_reg;
        prev_next        = prev_reg;
        hold_next        = hold_reg;
        hold_vld_next    = hold_vld_reg;

        if (emit_req && emit_ok)
        begin
            hold_next     = new_res;
            hold_vld_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_in.valid)
                begin
                    seq_next        = q_in.item.seq_num;
                    tag_next        = q_in.item.tag;
                    hold_ticks_next = q_in.item.hold_ticks;
                    if (q_in.item.command == CMD_TICK)
                    begin
                        time_next = time_reg + 32'd1;
                        idx_next  = wrap_add(oldest_slot_reg, CNT_W'(tick_d));
                        seq_next  = exp_reg;
                        cnt_next  = '0;
                        prev_next = 1'b0;
                    end
                end
            end
            ST_ARRIVE:
            begin
                exp_next   = arr_exp;
                rdl_next   = time_reg + 32'(resync_timeout);
                class_next = arr_inorder ? CL_INORDER : (arr_early ? CL_EARLY : CL_LATE);
                idx_next   = oldest_slot_reg;
                cnt_next   = '0;
                steps_next = steps_clip;
            end
            ST_SLIDE:
            begin
                if (cnt_reg == steps_reg)
                begin
                    oldest_slot_next = wrap_add(oldest_slot_reg, steps_reg);
                    oldest_seq_next  = new_oldest;
                    newest_seq_next  = seq_reg;
                    if (class_reg == CL_EARLY
                        && !(is_after(exp_reg, new_oldest - 32'd1)
                             && is_after(seq_reg + 32'd1, exp_reg)))
                    begin
                        exp_next = new_oldest;
                    end
                end
                else if (!stall)
                begin
                    full_next[idx_reg] = 1'b0;
                    sent_next[idx_reg] = 1'b0;
                    cnt_next = cnt_reg + 1'b1;
                    idx_next = idx_inc;
                end
            end
            ST_PLACE:
            begin
                idx_next = place_slot;
                cnt_next = '0;
                if (!place_hit)
                begin
                    verdict_next = VD_ACCEPT;
                end
                else if (full_reg[place_slot])
                begin
                    verdict_next = VD_DROP;
                end
                else
                begin
                    full_next[place_slot]    = 1'b1;
                    sent_next[place_slot]    = (class_reg == CL_LATE);
                    tag_mem_next[place_slot] = TAG_BITS'(tag_reg);
                    dl_mem_next[place_slot]  = (class_reg == CL_EARLY)
                                               ? time_reg + 32'(hold_ticks_reg) : time_reg;
                    verdict_next = (class_reg == CL_LATE) ? VD_ACCEPT : VD_QUEUED;
                end
            end
            ST_RUN:
            begin
                if (run_go && !stall)
                begin
                    sent_next[idx_reg] = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    exp_next = exp_reg + 32'd1;
                    idx_next = idx_inc;
                end
            end
            ST_TICK:
            begin
                if (cnt_reg != CNT_W'(RING_DEPTH) && !(cur_pend && !tick_rel) && !stall)
                begin
                    if (cur_pend)
                    begin
                        sent_next[idx_reg] = 1'b1;
                        exp_next  = seq_reg + 32'd1;
                        prev_next = 1'b1;
                    end
                    else
                    begin
                        prev_next = 1'b0;
                    end
                    seq_next = seq_reg + 32'd1;
                    idx_next = idx_inc;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (hold_vld_reg && !res_full)
                begin
                    hold_vld_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            for (int i = 0; i < RING_DEPTH; i++)
            begin
                full_reg[i] <= 1'b0;
                sent_reg[i] <= 1'b0;
            end
            oldest_slot_reg <= '0;
            oldest_seq_reg  <= '0;
            newest_seq_reg  <= 32'(RING_DEPTH - 1);
            exp_reg         <= '0;
            rdl_reg         <= '0;
            time_reg        <= '0;
            class_reg       <= CL_INORDER;
            idx_reg         <= '0;
            cnt_reg         <= '0;
            steps_reg       <= '0;
            prev_reg        <= 1'b0;
            hold_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            full_reg        <= full_next;
            sent_reg        <= sent_next;
            oldest_slot_reg <= oldest_slot_next;
            oldest_seq_reg  <= oldest_seq_next;
            newest_seq_reg  <= newest_seq_next;
            exp_reg         <= exp_next;
            rdl_reg         <= rdl_next;
            time_reg        <= time_next;
            class_reg       <= class_next;
            idx_reg         <= idx_next;
            cnt_reg         <= cnt_next;
            steps_reg       <= steps_next;
            prev_reg        <= prev_next;
            hold_vld_reg    <= hold_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_mem_reg    <= tag_mem_next;
        dl_mem_reg     <= dl_mem_next;
        seq_reg        <= seq_next;
        tag_reg        <= tag_next;
        hold_ticks_reg <= hold_ticks_next;
        verdict_reg    <= verdict_next;
        hold_reg       <= hold_next;
    end

`ifndef SYNTHESIS
    a_idle_no_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !hold_vld_reg)
        else $error("held result left over when idle");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(RING_DEPTH))
        else $error("walk count beyond ring depth");
    a_verdict_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_VERDICT && emit_ok) |=> (state_reg == ST_DONE && hold_vld_reg
                                                 && hold_reg.event_kind == EV_VERDICT))
        else $error("verdict not held for the final beat");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/sequence_reorder_buffer_top.sv =====
// top level: config register, input queue, engine and result queue
//
//   channel   handshake            payload
//   input     push / full          item   (command, seq_num, tag, hold_ticks)
//   result    pop / empty          result (event_kind, verdict, out_tag, out_seq, last)
//   config    psel/penable/pwrite  paddr, pwdata, prdata; pready tied high
//
// an arrival passes through classification, a slide of up to RING_DEPTH slots when the window
// moves, placement, a release run when an in-order packet is stored, and the verdict; a tick
// walks the ring slot by slot, or skips the walk when the expected number lies outside the window
// the engine walks the ring one slot per cycle while a full result queue does not stall it
// one item is in the engine at a time; up to two more wait in the input queue
// a full result queue stalls the engine at the next beat it produces
// reset clears the ring flags and pointers at once, no clearing pass
`default_nettype none

module sequence_reorder_buffer_top (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              push,
    output logic             full,
    input  srb_pkg::item_t   item,
    output logic             empty,
    input  wire              pop,
    output srb_pkg::result_t result,
    input  wire              psel,
    input  wire              penable,
    input  wire              pwrite,
    input  wire [2:0]        paddr,
    input  wire [31:0]       pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import srb_pkg::*;

    logic [15:0] timeout_reg, timeout_next;
    front_q_t    fq;
    logic        q_pop;
    logic        res_push, res_full;
    result_t     res_data;
    logic        reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign prdata  = (reg_idx == REG_TIMEOUT) ? {16'd0, timeout_reg} : 32'd0;

    always_comb
    begin
        timeout_next = timeout_reg;
        if (psel && penable && pwrite && pready && reg_idx == REG_TIMEOUT)
        begin
            timeout_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else
        begin
            timeout_reg <= timeout_next;
        end
    end

    srb_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .item  (item),
        .q_out (fq),
        .q_pop (q_pop)
    );

    srb_engine u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_in           (fq),
        .q_pop          (q_pop),
        .resync_timeout (timeout_reg),
        .res_push       (res_push),
        .res_data       (res_data),
        .res_full       (res_full)
    );

    srb_res_q u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_data),
        .wr_full (res_full),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

`default_nettype wire

// ===== tb/sequence_reorder_buffer_top_tb.sv =====
// self-checking testbench of the sequence reorder buffer: predictor, scoreboard and drivers
`default_nettype none

module sequence_reorder_buffer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srb_pkg::*;

    localparam int DEPTH      = 16;
    localparam int DRAIN_WAIT = 80;
    localparam int CYCLE_CAP  = 400000;

    // ring predictor plus the queue of expected result beats
    class reorder_scoreboard;
        logic        held [DEPTH];
        logic        done [DEPTH];
        logic [15:0] held_tag [DEPTH];
        logic [31:0] held_due [DEPTH];
        logic [3:0]  head_slot;
        logic [31:0] win_first;
        logic [31:0] win_newest;
        logic [31:0] next_seq;
        logic [31:0] resync_at;
        logic [31:0] now;
        logic [15:0] timeout;
        result_t     pending_q[$];
        result_t     step_q[$];
        int          mismatches;
        int          checked;
        int          verdicts [3];

        function new();
            for (int i = 0; i < DEPTH; i++)
            begin
                held[i] = 1'b0;
                done[i] = 1'b0;
                held_tag[i] = '0;
                held_due[i] = '0;
            end
            head_slot = '0;
            win_first = '0;
            win_newest = DEPTH - 1;
            next_seq = '0;
            resync_at = '0;
            now = '0;
            timeout = TIMEOUT_RESET;
            mismatches = 0;
            checked = 0;
            verdicts = '{0, 0, 0};
        endfunction

        function automatic logic later(logic [31:0] a, logic [31:0] b);
            logic [31:0] d;
            d = b - a;
            return d[31];
        endfunction

        function automatic logic covers(logic [31:0] s);
            return later(s, win_first - 1) && later(win_newest + 1, s);
        endfunction

        function automatic logic locate(logic [31:0] s, output logic [3:0] idx);
            logic [31:0] d;
            d = s - win_first;
            idx = head_slot + d[3:0];
            return d < DEPTH;
        endfunction

        function void add_beat(logic k, logic [1:0] v, logic [15:0] t, logic [31:0] s);
            result_t r;
            r.event_kind = k;
            r.verdict = v;
            r.out_tag = t;
            r.out_seq = s;
            r.last = 1'b0;
            step_q.push_back(r);
        endfunction

        function void slide(logic [31:0] s);
            logic [31:0] steps;
            logic [3:0]  idx;
            steps = s - win_newest;
            if (steps > DEPTH)
                steps = DEPTH;
            for (int i = 0; i < steps; i++)
            begin
                idx = head_slot + i[3:0];
                if (held[idx] && !done[idx])
                    add_beat(EV_FORWARD, VD_ACCEPT, held_tag[idx], win_first + i);
                held[idx] = 1'b0;
                done[idx] = 1'b0;
            end
            head_slot = head_slot + steps[3:0];
            win_first = s - DEPTH + 1;
            win_newest = s;
        endfunction

        function void keep(logic [3:0] idx, logic [15:0] t, logic sent, logic [31:0] due);
            held[idx] = 1'b1;
            done[idx] = sent;
            held_tag[idx] = t;
            held_due[idx] = due;
        endfunction

        function logic [1:0] arrival(logic [31:0] s, logic [15:0] t, logic [15:0] hold);
            logic [3:0]  idx;
            logic [31:0] d;
            logic [31:0] sq;
            d = now - resync_at;
            if (!d[31])
                next_seq = s;
            resync_at = now + timeout;
            if (s == next_seq)
            begin
                if (!covers(s))
                    slide(s);
                if (!locate(s, idx))
                    return VD_ACCEPT;
                if (held[idx])
                    return VD_DROP;
                keep(idx, t, 1'b0, now);
                // in-order packet frees the run of waiting ones behind it
                sq = s;
                for (int c = 0; c < DEPTH; c++)
                begin
                    if (!(held[idx] && !done[idx]))
                        break;
                    add_beat(EV_FORWARD, VD_ACCEPT, held_tag[idx], sq);
                    done[idx] = 1'b1;
                    sq++;
                    idx++;
                end
                next_seq = sq;
                return VD_QUEUED;
            end
            if (later(s, next_seq))
            begin
                if (!covers(s))
                begin
                    slide(s);
                    if (!covers(next_seq))
                        next_seq = win_first;
                end
                if (!locate(s, idx))
                    return VD_ACCEPT;
                if (held[idx])
                    return VD_DROP;
                keep(idx, t, 1'b0, now + hold);
                return VD_QUEUED;
            end
            if (!locate(s, idx))
                return VD_ACCEPT;
            if (held[idx])
                return VD_DROP;
            keep(idx, t, 1'b1, now);
            return VD_ACCEPT;
        endfunction

        function void tick();
            logic [3:0]  idx;
            logic [31:0] sq;
            logic        chain;
            now++;
            sq = next_seq;
            chain = 1'b0;
            if (!locate(next_seq, idx))
                return;
            for (int i = 0; i < DEPTH; i++)
            begin
                if (held[idx] && !done[idx])
                begin
                    if (chain || later(now, held_due[idx]))
                    begin
                        add_beat(EV_FORWARD, VD_ACCEPT, held_tag[idx], sq);
                        done[idx] = 1'b1;
                        next_seq = sq + 1;
                        chain = 1'b1;
                    end
                    else
                        break;
                end
                else
                    chain = 1'b0;
                sq++;
                idx++;
            end
        endfunction

        function void note_item(item_t it);
            logic [1:0] v;
            step_q.delete();
            if (it.command == CMD_ARRIVE)
            begin
                v = arrival(it.seq_num, it.tag, it.hold_ticks);
                verdicts[v]++;
                add_beat(EV_VERDICT, v, it.tag, it.seq_num);
            end
            else
                tick();
            if (step_q.size() > 0)
                step_q[step_q.size() - 1].last = 1'b1;
            foreach (step_q[i])
                pending_q.push_back(step_q[i]);
        endfunction

        function void check_result(result_t got);
            result_t want;
            checked++;
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %p", got);
                return;
            end
            want = pending_q.pop_front();
            if (got.event_kind !== want.event_kind || got.verdict !== want.verdict ||
                got.out_tag !== want.out_tag || got.out_seq !== want.out_seq ||
                got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p, actual %p", want, got);
            end
        endfunction

        function void set_timeout(logic [15:0] v);
            timeout = v;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    item_t       item;
    logic        empty;
    logic        pop;
    result_t     result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    reorder_scoreboard sb;
    logic    full_seen;
    logic    empty_seen;
    result_t result_seen;
    int      cycles;
    int      sent_count;
    int      tick_count;

    sequence_reorder_buffer_top DUT (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full), .item(item),
        .empty(empty), .pop(pop), .result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // outputs are sampled half a period ahead of the edge that uses them
    always @(negedge clk)
    begin
        full_seen <= full;
        empty_seen <= empty;
        result_seen <= result;
    end

    // no idling over a middle stretch of the run
    function automatic logic take_break(int pos);
        if (pos >= 150 && pos < 240)
            return 1'b0;
        return $urandom_range(0, 99) < 10;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
        if (rst_n && pop && !empty_seen)
            sb.check_result(result_seen);
        pop <= !take_break(cycles / 40);
    end

    task automatic send_item(item_t it);
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full_seen)
            @(posedge clk);
        sb.note_item(it);
        sent_count++;
        if (it.command == CMD_TICK)
            tick_count++;
        if (take_break(sent_count))
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic send_arrival(logic [31:0] s, logic [15:0] t, logic [15:0] hold);
        item_t it;
        it.command = CMD_ARRIVE;
        it.seq_num = s;
        it.tag = t;
        it.hold_ticks = hold;
        send_item(it);
    endtask

    task automatic send_tick();
        item_t it;
        it.command = CMD_TICK;
        it.seq_num = $urandom;
        it.tag = 16'($urandom);
        it.hold_ticks = 16'($urandom);
        send_item(it);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_timeout(logic [15:0] v);
        wait_drained();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(REG_TIMEOUT) << 2;
        pwdata <= {16'h0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_timeout(v);
    endtask

    // mostly near the expected number so the ring fills and drains
    task automatic send_random(int count);
        int          pick;
        logic [31:0] s;
        logic [15:0] hold;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 18)
                send_tick();
            else
            begin
                if (pick < 26)
                    s = $urandom;
                else if (pick < 32)
                    s = sb.next_seq + $urandom_range(16, 40);
                else if (pick < 36)
                    s = sb.next_seq - $urandom_range(16, 3000);
                else
                    s = sb.next_seq + $urandom_range(0, 9) - 3;
                hold = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
                send_arrival(s, 16'($urandom), hold);
            end
        end
    endtask

    initial
    begin
        sb = new();
        cycles = 0;
        sent_count = 0;
        tick_count = 0;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        full_seen = 1'b1;
        empty_seen = 1'b1;
        result_seen = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: sync, in order, early, duplicate, release, late, slides
        send_arrival(32'd0, 16'h0000, 16'd0);
        send_arrival(32'd1, 16'hFFFF, 16'hFFFF);
        send_arrival(32'd3, 16'h1234, 16'd0);
        send_arrival(32'd3, 16'h4321, 16'd0);
        send_arrival(32'd5, 16'h5555, 16'd1);
        send_arrival(32'd6, 16'h6666, 16'd9);
        send_tick();
        send_tick();
        send_tick();
        send_arrival(32'd2, 16'h2222, 16'd0);
        send_arrival(32'd2, 16'h2223, 16'd0);
        send_arrival(32'hFFFF_FF00, 16'hAAAA, 16'd0);
        send_arrival(32'd9, 16'h0009, 16'd3);
        send_arrival(32'd10, 16'h000A, 16'd3);
        send_arrival(32'd40, 16'h0028, 16'd2);
        send_arrival(32'h8000_0028, 16'h8000, 16'hFFFF);
        send_arrival(32'hFFFF_FFFF, 16'hFFFF, 16'd0);
        send_tick();
        send_arrival(32'd0, 16'h0001, 16'd0);
        send_tick();

        send_random(100);
        write_timeout(16'd1);
        send_random(90);
        write_timeout(16'hFFFF);
        send_random(90);
        write_timeout(16'd0);
        send_random(30);
        write_timeout(16'd5);
        send_random(40);

        wait_drained();
        $display("items sent: %0d (%0d ticks), result beats checked: %0d",
                 sent_count, tick_count, sb.checked);
        $display("verdicts accept/queued/drop: %0d/%0d/%0d, timeout settings 1000,1,65535,0,5",
                 sb.verdicts[0], sb.verdicts[1], sb.verdicts[2]);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("Simulation PASSED");
        else
        begin
            $display("%0d mismatches, %0d beats missing", sb.mismatches, sb.pending_q.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
